[src/byte_unicode_utf8_codec_defines.svh]
// ----------------------------------------------------------------------------
// Byte unicode UTF-8 codec assertion macros
// Shared concurrent check forms, all reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BYTE_UNICODE_UTF8_CODEC_DEFINES_SVH
`define BYTE_UNICODE_UTF8_CODEC_DEFINES_SVH

// Same-cycle implication.
`define BU8C_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define BU8C_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

[src/bu8c_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bu8c_pkg
// Word types, job record and byte/code-point mapping for the codec.
// ----------------------------------------------------------------------------
package bu8c_pkg;

  localparam logic [7:0] QMARK     = 8'h3F;
  localparam logic [7:0] LEAD2     = 8'hC0;
  localparam logic [7:0] CONT_MARK = 8'h80;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
  } out_word_t;

  // One job per item that yields output: one or two bytes.
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } job_t;

  function automatic logic is_kept(input logic [7:0] b);
    return (b >= 8'h21 && b <= 8'h7E) || (b >= 8'hA1 && b <= 8'hAC) || (b >= 8'hAE);
  endfunction

  // Raw byte to byte-level code point (0..323).
  function automatic logic [8:0] byte_to_cp(input logic [7:0] b);
    logic [8:0] cp;
    if (is_kept(b)) begin
      cp = {1'b0, b};
    end else if (b <= 8'h20) begin
      cp = {1'b1, b};
    end else if (b == 8'hAD) begin
      cp = 9'd323;
    end else begin
      // 0x7F..0xA0 rank from 33
      cp = {1'b1, b - 8'h5E};
    end
    return cp;
  endfunction

  // Code point back to raw byte, '?' when nothing maps to it.
  function automatic logic [7:0] cp_to_byte(input logic [20:0] cp);
    logic [7:0] r;
    r = cp[7:0];
    if (cp[20:8] == 13'd0) begin
      return is_kept(r) ? r : QMARK;
    end else if (cp[20:9] == 12'd0 && r < 8'd68) begin
      if (r < 8'd33) begin
        return r;
      end else if (r < 8'd67) begin
        return r + 8'h5E;
      end else begin
        return 8'hAD;
      end
    end
    return QMARK;
  endfunction

endpackage

[src/bu8c_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bu8c_fifo
// Small register queue of jobs between front and back.
// ----------------------------------------------------------------------------
`include "byte_unicode_utf8_codec_defines.svh"

module bu8c_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  bu8c_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd_en,
  output bu8c_pkg::job_t rd_job,
  output logic           empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bu8c_pkg::job_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `BU8C_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `BU8C_ASSERT_IMPL(a_no_overflow, clk, rst, wr_en, !full)
  `BU8C_ASSERT_IMPL(a_no_underflow, clk, rst, rd_en, !empty)

endmodule

[src/bu8c_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bu8c_front
// Accepts input words, holds direction and decode state, builds output jobs.
// ----------------------------------------------------------------------------
module bu8c_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_data,
  input  logic             accept,
  input  bu8c_pkg::in_word_t in_word,
  output logic             job_push,
  output bu8c_pkg::job_t   job
);

  logic        direction;
  logic [1:0]  pending;
  logic [20:0] accum;
  logic [1:0]  pending_next;
  logic [20:0] accum_next;
  logic [8:0]  cp;
  logic [7:0]  b;

  assign b  = in_word.in_byte;
  assign cp = bu8c_pkg::byte_to_cp(b);

  always_comb begin
    job_push     = 1'b0;
    job          = '0;
    job.last     = in_word.stream_last;
    pending_next = pending;
    accum_next   = accum;
    if (!direction) begin
      job_push = accept;
      if (cp[8:7] == 2'b00) begin
        job.b0 = cp[7:0];
      end else begin
        job.two = 1'b1;
        job.b0  = bu8c_pkg::LEAD2 | {5'd0, cp[8:6]};
        job.b1  = bu8c_pkg::CONT_MARK | {2'd0, cp[5:0]};
      end
    end else begin
      if (pending == 2'd0) begin
        priority if (!b[7]) begin
          accum_next   = {13'd0, b};
          pending_next = 2'd0;
        end else if (b[7:5] == 3'b110) begin
          accum_next   = {16'd0, b[4:0]};
          pending_next = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          accum_next   = {17'd0, b[3:0]};
          pending_next = 2'd2;
        end else begin
          // stray continuation and 0xF0+ all open four bytes
          accum_next   = {18'd0, b[2:0]};
          pending_next = 2'd3;
        end
      end else begin
        accum_next   = {accum[14:0], b[5:0]};
        pending_next = pending - 2'd1;
      end
      if (pending_next == 2'd0) begin
        job_push = accept;
        job.b0   = bu8c_pkg::cp_to_byte(accum_next);
      end else if (in_word.stream_last) begin
        // sequence cut short at stream end
        job_push = accept;
        job.b0   = bu8c_pkg::QMARK;
      end
      if (pending_next == 2'd0 || in_word.stream_last) begin
        pending_next = 2'd0;
        accum_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      pending   <= 2'd0;
      accum     <= '0;
    end else if (cfg_we) begin
      direction <= cfg_data;
      pending   <= 2'd0;
      accum     <= '0;
    end else if (accept && direction) begin
      pending <= pending_next;
      accum   <= accum_next;
    end
  end

endmodule

[src/bu8c_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bu8c_back
// Expands queued jobs into output words through an output register.
// ----------------------------------------------------------------------------
`include "byte_unicode_utf8_codec_defines.svh"

module bu8c_back (
  input  logic                clk,
  input  logic                rst,
  input  bu8c_pkg::job_t      q_job,
  input  logic                q_empty,
  output logic                q_pop,
  output bu8c_pkg::out_word_t out_word,
  output logic                empty,
  input  logic                pop
);

  logic                out_valid;
  bu8c_pkg::out_word_t out_q;
  logic                sec_pend;
  logic [7:0]          sec_byte;
  logic                sec_last;
  logic                out_load;

  assign empty    = !out_valid;
  assign out_word = out_q;
  assign out_load = !out_valid || pop;
  assign q_pop    = out_load && !sec_pend && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sec_pend  <= 1'b0;
    end else if (out_load) begin
      if (sec_pend) begin
        out_valid <= 1'b1;
        sec_pend  <= 1'b0;
      end else begin
        out_valid <= !q_empty;
        sec_pend  <= !q_empty && q_job.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (sec_pend) begin
        out_q <= '{out_byte: sec_byte, run_last: 1'b1, stream_end: sec_last};
      end else begin
        // hold second byte of a pair until the first drains
        out_q    <= '{out_byte: q_job.b0, run_last: !q_job.two,
                      stream_end: q_job.last && !q_job.two};
        sec_byte <= q_job.b1;
        sec_last <= q_job.last;
      end
    end
  end

  `BU8C_ASSERT_IMPL(a_pair_head, clk, rst, sec_pend, out_valid && !out_q.run_last)
  `BU8C_ASSERT_NEXT(a_pair_drain, clk, rst, sec_pend && out_load, !sec_pend)
  `BU8C_ASSERT_IMPL(a_no_pop_in_pair, clk, rst, q_pop, !sec_pend)

endmodule

[src/byte_unicode_utf8_codec.sv]
`timescale 1ns / 1ps
// Path: each output job is queued, then its first byte enters the output register.
// Throughput: one input word per cycle if pop keeps up and each yields at most one
// byte; a two-byte encoding holds the output register for both bytes, so a run of
// them backs up the job queue (QUEUE_DEPTH entries), which also absorbs short output
// stalls; once it fills, full rises.
// Reset: direction returns to encode, decode state, queue and output register clear.
// ----------------------------------------------------------------------------
// byte_unicode_utf8_codec
// Byte to byte-level code point UTF-8 encoder and matching decoder.
// ----------------------------------------------------------------------------
module byte_unicode_utf8_codec #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_data,
  input  logic                push,
  output logic                full,
  input  bu8c_pkg::in_word_t  in_word,
  input  logic                pop,
  output logic                empty,
  output bu8c_pkg::out_word_t out_word
);

  logic           accept;
  logic           job_push;
  bu8c_pkg::job_t job;
  bu8c_pkg::job_t q_job;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  bu8c_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .in_word  (in_word),
    .job_push (job_push),
    .job      (job)
  );

  bu8c_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (job),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  bu8c_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_job    (q_job),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_word (out_word),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte unicode UTF-8 codec: a tracker keeps its
// own encode/decode state, queues the bytes each accepted word should yield
// and matches every popped word against them. Directed corners come first,
// then random phases in both directions with idle gaps and a long output stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT      = 24;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  class codec_tracker;
    dir_e                expected_dir;
    logic [1:0]          cont_left;
    logic [20:0]         point_acc;
    bu8c_pkg::out_word_t expected_bytes[$];
    int                  mismatches;

    function new();
      expected_dir = DIR_ENCODE;
      cont_left    = '0;
      point_acc    = '0;
      mismatches   = 0;
    endfunction

    function logic [8:0] raw_to_point(logic [7:0] b);
      if ((b >= 8'h21 && b <= 8'h7E) || (b >= 8'hA1 && b <= 8'hAC) || b >= 8'hAE) begin
        return {1'b0, b};
      end
      if (b <= 8'h20) begin
        return 9'd256 + b;
      end
      if (b == 8'hAD) begin
        return 9'd323;
      end
      return 9'd289 + (b - 8'h7F);
    endfunction

    // Anything outside the kept set and the 68 shifted points becomes '?'.
    function logic [7:0] point_to_raw(logic [20:0] cp);
      logic [20:0] rank;
      rank = cp - 21'd256;
      if ((cp >= 21'h21 && cp <= 21'h7E) || (cp >= 21'hA1 && cp <= 21'hAC) ||
          (cp >= 21'hAE && cp <= 21'hFF)) begin
        return cp[7:0];
      end
      if (cp >= 21'd256 && cp < 21'd324) begin
        if (rank < 21'd33) begin
          return rank[7:0];
        end else if (rank < 21'd67) begin
          return 8'h7F + (rank[7:0] - 8'd33);
        end
        return 8'hAD;
      end
      return bu8c_pkg::QMARK;
    endfunction

    function void set_direction(dir_e d);
      expected_dir = d;
      cont_left    = '0;
      point_acc    = '0;
    endfunction

    function void push_expect(logic [7:0] b, logic rl, logic se);
      bu8c_pkg::out_word_t w;
      w.out_byte   = b;
      w.run_last   = rl;
      w.stream_end = se;
      expected_bytes.insert(expected_bytes.size(), w);
    endfunction

    function void take_in_word(bu8c_pkg::in_word_t w);
      logic [8:0] cp;
      if (expected_dir == DIR_ENCODE) begin
        cp = raw_to_point(w.in_byte);
        if (cp < 9'h080) begin
          push_expect(cp[7:0], 1'b1, w.stream_last);
        end else begin
          push_expect(8'hC0 | {5'b0, cp[8:6]}, 1'b0, 1'b0);
          push_expect(8'h80 | {2'b0, cp[5:0]}, 1'b1, w.stream_last);
        end
        return;
      end
      if (cont_left == 2'd0) begin
        if (!w.in_byte[7]) begin
          point_acc = {13'b0, w.in_byte};
        end else if (w.in_byte[7:5] == 3'b110) begin
          point_acc = {16'b0, w.in_byte[4:0]};
          cont_left = 2'd1;
        end else if (w.in_byte[7:4] == 4'b1110) begin
          point_acc = {17'b0, w.in_byte[3:0]};
          cont_left = 2'd2;
        end else begin
          // stray continuation or 0xF0+ lead: open four bytes
          point_acc = {18'b0, w.in_byte[2:0]};
          cont_left = 2'd3;
        end
      end else begin
        point_acc = {point_acc[14:0], w.in_byte[5:0]};
        cont_left = cont_left - 2'd1;
      end
      if (cont_left == 2'd0) begin
        push_expect(point_to_raw(point_acc), 1'b1, w.stream_last);
        point_acc = '0;
      end else if (w.stream_last) begin
        // sequence cut short by the end of the stream
        push_expect(bu8c_pkg::QMARK, 1'b1, 1'b1);
        cont_left = '0;
        point_acc = '0;
      end
    endfunction

    function void match_out_word(bu8c_pkg::out_word_t got);
      bu8c_pkg::out_word_t want;
      if (expected_bytes.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected word: byte %h run_last %b stream_end %b",
                   got.out_byte, got.run_last, got.stream_end);
        end
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
          got.stream_end !== want.stream_end) begin
        if (mismatches < 10) begin
          $display({"mismatch: byte exp %h got %h, run_last exp %b got %b, ",
                    "stream_end exp %b got %b"},
                   want.out_byte, got.out_byte, want.run_last, got.run_last,
                   want.stream_end, got.stream_end);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic                cfg_data;
  logic                push;
  logic                full;
  bu8c_pkg::in_word_t  in_word;
  logic                pop;
  logic                empty;
  bu8c_pkg::out_word_t out_word;

  codec_tracker board;
  bit           tx_idle_on;
  bit           rx_idle_on;
  int           hold_cycles;

  byte_unicode_utf8_codec DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .pop      (pop),
    .empty    (empty),
    .out_word (out_word)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Result side: check each popped word, then pick the next pop, or hold off.
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        board.match_out_word(out_word);
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_cycles > 0) begin
        pop <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        pop <= !rx_idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  task automatic send_byte(logic [7:0] b, logic last);
    bu8c_pkg::in_word_t w;
    w.in_byte     = b;
    w.stream_last = last;
    if (tx_idle_on) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push    <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    board.take_in_word(w);
  endtask

  // Drop push, wait for every expected word, then let trailing work finish.
  task automatic settle();
    push <= 1'b0;
    while (board.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(dir_e d);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_direction(d);
  endtask

  // One decode unit: mostly well-formed encodings of raw bytes, then random
  // multi-byte sequences, then noise; stream ends land anywhere.
  task automatic send_decode_unit(output int sent);
    logic [7:0] seq[$];
    logic [8:0] cp;
    int         pick;
    int         conts;
    pick  = $urandom_range(0, 99);
    conts = 0;
    if (pick < 60) begin
      cp = board.raw_to_point(8'($urandom_range(0, 255)));
      if (cp < 9'h080) begin
        seq.insert(seq.size(), cp[7:0]);
      end else begin
        seq.insert(seq.size(), 8'hC0 | {5'b0, cp[8:6]});
        seq.insert(seq.size(), 8'h80 | {2'b0, cp[5:0]});
      end
    end else begin
      if (pick < 72) begin
        seq.insert(seq.size(), 8'hC0 | 8'($urandom_range(0, 31)));
        conts = 1;
      end else if (pick < 82) begin
        seq.insert(seq.size(), 8'hE0 | 8'($urandom_range(0, 15)));
        conts = 2;
      end else if (pick < 90) begin
        if ($urandom_range(0, 1) == 0) begin
          seq.insert(seq.size(), 8'hF0 | 8'($urandom_range(0, 15)));
        end else begin
          seq.insert(seq.size(), 8'h80 | 8'($urandom_range(0, 63)));
        end
        conts = 3;
      end else begin
        seq.insert(seq.size(), 8'($urandom_range(0, 255)));
      end
      repeat (conts) begin
        if ($urandom_range(0, 4) == 0) begin
          seq.insert(seq.size(), 8'($urandom_range(0, 255)));
        end else begin
          seq.insert(seq.size(), 8'h80 | 8'($urandom_range(0, 63)));
        end
      end
    end
    for (int i = 0; i < seq.size(); i++) begin
      if (i == seq.size() - 1) begin
        send_byte(seq[i], $urandom_range(0, 99) < 6);
      end else begin
        send_byte(seq[i], $urandom_range(0, 99) < 3);
      end
    end
    sent = seq.size();
  endtask

  task automatic run_phase(dir_e d, int count, bit tx_idle, bit rx_idle, int hold);
    int done;
    int sent;
    write_direction(d);
    tx_idle_on  = tx_idle;
    rx_idle_on  = rx_idle;
    hold_cycles = hold;
    done        = 0;
    while (done < count) begin
      if (d == DIR_DECODE) begin
        send_decode_unit(sent);
        done += sent;
      end else begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 6);
        done++;
      end
    end
  endtask

  initial begin
    board       = new();
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_data   <= 1'b0;
    push       <= 1'b0;
    in_word    <= '0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    hold_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // encode: range edges of the kept and shifted bytes
    write_direction(DIR_ENCODE);
    send_byte(8'h00, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h21, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'hAD, 1'b0);
    send_byte(8'hFF, 1'b1);

    write_direction(DIR_DECODE);
    send_byte(8'h41, 1'b0);
    send_byte(8'hC4, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC5, 1'b0);
    send_byte(8'h83, 1'b0);
    // first point past the shifted range
    send_byte(8'hC5, 1'b0);
    send_byte(8'h84, 1'b0);
    // overlong 'a'
    send_byte(8'hC1, 1'b0);
    send_byte(8'hA1, 1'b0);
    // stray continuation as a lead
    send_byte(8'h85, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // 0xF8 lead, continuation bits unchecked
    send_byte(8'hF8, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC4, 1'b1);
    send_byte(8'h41, 1'b1);
    // register write abandons an open sequence
    send_byte(8'hC4, 1'b0);
    write_direction(DIR_DECODE);
    send_byte(8'h41, 1'b0);

    run_phase(DIR_DECODE, 300, 1'b1, 1'b1, 0);
    run_phase(DIR_ENCODE, 250, 1'b1, 1'b1, 400);
    run_phase(DIR_DECODE, 250, 1'b1, 1'b1, 0);
    run_phase(DIR_ENCODE, 200, 1'b0, 1'b0, 0);
    run_phase(DIR_DECODE, 250, 1'b0, 1'b0, 0);
    settle();

    if (board.mismatches == 0 && board.expected_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[byte_unicode_utf8_codec.f]
+incdir+src
src/bu8c_pkg.sv
src/bu8c_fifo.sv
src/bu8c_front.sv
src/bu8c_back.sv
src/byte_unicode_utf8_codec.sv
tb/tb.sv
